@@ sv/bpa_pkg.sv @@
// Shared types, widths and helpers for the barycentric projected-area block.
// Used by the channel interfaces, every module and the checker.
package bpa_pkg;

    localparam int COORD_BITS       = 24;
    localparam int WEIGHT_FRAC_BITS = 24;
    localparam int WEIGHT_BITS      = 32;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int AREA_W = PROD_W + 1;
    localparam int MAG_W  = AREA_W - 1;
    localparam int DVD_W  = MAG_W + WEIGHT_FRAC_BITS;
    localparam int Q_W    = DVD_W + 1;
    localparam int WIDE_W = Q_W + 2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef logic signed [COORD_BITS-1:0]  coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [AREA_W-1:0]      area_t;
    typedef logic        [MAG_W-1:0]       mag_t;
    typedef logic signed [Q_W-1:0]         quot_t;
    typedef logic signed [WIDE_W-1:0]      wide_t;
    typedef logic signed [WEIGHT_BITS-1:0] weight_t;

    localparam wide_t W_HI  = wide_t'(2**(WEIGHT_BITS-1) - 1);
    localparam wide_t W_LO  = -W_HI - wide_t'(1);
    localparam wide_t W_ONE = wide_t'(2**WEIGHT_FRAC_BITS);

    typedef struct packed {
        diff_t x;
        diff_t y;
        diff_t z;
    } vec3_t;

    // state handed from one divider cell to the next
    typedef struct packed {
        logic             valid;
        logic             degen;
        logic             neg_u;
        logic             neg_v;
        mag_t             dmag;
        logic [DVD_W-1:0] nu;
        logic [DVD_W-1:0] nv;
        mag_t             ru;
        mag_t             rv;
        logic [DVD_W-1:0] qu;
        logic [DVD_W-1:0] qv;
    } div_t;

    function automatic diff_t dsub(coord_t a, coord_t b);
        dsub = diff_t'(a) - diff_t'(b);
    endfunction

    function automatic prod_t pmul(diff_t a, diff_t b);
        pmul = prod_t'(a) * prod_t'(b);
    endfunction

    function automatic diff_t pick(vec3_t v, logic [1:0] ax);
        unique case (ax)
            AXIS_X:  pick = v.x;
            AXIS_Y:  pick = v.y;
            default: pick = v.z;
        endcase
    endfunction

    function automatic mag_t amag(area_t a);
        amag = MAG_W'(a[AREA_W-1] ? -a : a);
    endfunction

endpackage

@@ sv/bpa_if.sv @@
// Channel interfaces: triangle/point items in, barycentric weights out.
// Depends on bpa_pkg.
interface bpa_item_if;
    import bpa_pkg::*;
    logic   valid;
    logic   ready;
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz;
    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz,
                    input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz,
                    output ready);
endinterface

interface bpa_result_if;
    import bpa_pkg::*;
    logic    valid;
    logic    ready;
    weight_t weight_u, weight_v, weight_w;
    logic    degenerate;
    modport source (output valid, weight_u, weight_v, weight_w, degenerate,
                    input ready);
    modport sink   (input valid, weight_u, weight_v, weight_w, degenerate,
                    output ready);
endinterface

@@ sv/bpa_front.sv @@
// Front pipeline: edge vectors, normal, axis choice and projected areas.
// Feeds the divider chain. Depends on bpa_pkg and bpa_item_if.
module bpa_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    bpa_item_if.sink      item,
    output bpa_pkg::div_t dout
);
    import bpa_pkg::*;

    // stage 1: differences
    logic  s1_valid_reg;
    vec3_t ab_reg, bc_reg, ca_reg, bp_reg, cp_reg;
    // stage 2: normal products
    logic  s2_valid_reg;
    prod_t n0a_reg, n0b_reg, n1a_reg, n1b_reg, n2a_reg, n2b_reg;
    vec3_t bc2_reg, ca2_reg, bp2_reg, cp2_reg;
    // stage 3: normal, axis
    logic  s3_valid_reg, s3_degen_reg;
    logic [1:0] axis_reg;
    area_t dsel_reg;
    vec3_t bc3_reg, ca3_reg, bp3_reg, cp3_reg;
    // stage 4: numerator products
    logic  s4_valid_reg, s4_degen_reg, neg_d_reg;
    mag_t  dmag_reg;
    prod_t u1_reg, u2_reg, v1_reg, v2_reg;
    // stage 5: numerator magnitudes
    logic  s5_valid_reg, s5_degen_reg, neg_u_reg, neg_v_reg;
    mag_t  dmag5_reg, umag_reg, vmag_reg;

    area_t d0, d1, d2, un, vn;
    mag_t  m0, m1, m2;
    logic [1:0] axis_next, ai, aj;

    assign item.ready = adv;

    always_comb
    begin
        d0 = area_t'(n0a_reg) - area_t'(n0b_reg);
        d1 = area_t'(n1a_reg) - area_t'(n1b_reg);
        d2 = area_t'(n2a_reg) - area_t'(n2b_reg);
        m0 = amag(d0);
        m1 = amag(d1);
        m2 = amag(d2);
        priority if (m0 >= m1 && m0 >= m2)
            axis_next = AXIS_X;
        else if (m1 >= m2)
            axis_next = AXIS_Y;
        else
            axis_next = AXIS_Z;
        ai = (axis_reg == AXIS_X) ? AXIS_Y : AXIS_X;
        aj = (axis_reg == AXIS_Z) ? AXIS_Y : AXIS_Z;
        un = area_t'(u1_reg) - area_t'(u2_reg);
        vn = area_t'(v1_reg) - area_t'(v2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= item.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ab_reg <= '{dsub(item.bx, item.ax), dsub(item.by, item.ay), dsub(item.bz, item.az)};
            bc_reg <= '{dsub(item.cx, item.bx), dsub(item.cy, item.by), dsub(item.cz, item.bz)};
            ca_reg <= '{dsub(item.ax, item.cx), dsub(item.ay, item.cy), dsub(item.az, item.cz)};
            bp_reg <= '{dsub(item.bx, item.px), dsub(item.by, item.py), dsub(item.bz, item.pz)};
            cp_reg <= '{dsub(item.cx, item.px), dsub(item.cy, item.py), dsub(item.cz, item.pz)};

            n0a_reg <= pmul(ab_reg.y, bc_reg.z);
            n0b_reg <= pmul(bc_reg.y, ab_reg.z);
            n1a_reg <= pmul(ab_reg.x, bc_reg.z);
            n1b_reg <= pmul(bc_reg.x, ab_reg.z);
            n2a_reg <= pmul(ab_reg.x, bc_reg.y);
            n2b_reg <= pmul(bc_reg.x, ab_reg.y);
            bc2_reg <= bc_reg;
            ca2_reg <= ca_reg;
            bp2_reg <= bp_reg;
            cp2_reg <= cp_reg;

            axis_reg     <= axis_next;
            s3_degen_reg <= (m0 == '0) && (m1 == '0) && (m2 == '0);
            unique case (axis_next)
                AXIS_X:  dsel_reg <= d0;
                AXIS_Y:  dsel_reg <= d1;
                default: dsel_reg <= d2;
            endcase
            bc3_reg <= bc2_reg;
            ca3_reg <= ca2_reg;
            bp3_reg <= bp2_reg;
            cp3_reg <= cp2_reg;

            // area(P,B,C) and area(P,C,A) in the kept plane
            u1_reg       <= pmul(pick(bp3_reg, ai), pick(bc3_reg, aj));
            u2_reg       <= pmul(pick(bc3_reg, ai), pick(bp3_reg, aj));
            v1_reg       <= pmul(pick(cp3_reg, ai), pick(ca3_reg, aj));
            v2_reg       <= pmul(pick(ca3_reg, ai), pick(cp3_reg, aj));
            dmag_reg     <= amag(dsel_reg);
            neg_d_reg    <= dsel_reg[AREA_W-1];
            s4_degen_reg <= s3_degen_reg;

            umag_reg     <= amag(un);
            vmag_reg     <= amag(vn);
            neg_u_reg    <= un[AREA_W-1] ^ neg_d_reg;
            neg_v_reg    <= vn[AREA_W-1] ^ neg_d_reg;
            dmag5_reg    <= dmag_reg;
            s5_degen_reg <= s4_degen_reg;
        end
    end

    always_comb
    begin
        dout.valid = s5_valid_reg;
        dout.degen = s5_degen_reg;
        dout.neg_u = neg_u_reg;
        dout.neg_v = neg_v_reg;
        dout.dmag  = dmag5_reg;
        dout.nu    = {umag_reg, {WEIGHT_FRAC_BITS{1'b0}}};
        dout.nv    = {vmag_reg, {WEIGHT_FRAC_BITS{1'b0}}};
        dout.ru    = '0;
        dout.rv    = '0;
        dout.qu    = '0;
        dout.qv    = '0;
    end

endmodule

@@ sv/bpa_div_cell.sv @@
// One restoring-division cell: produces one quotient bit of u and of v.
// Depends on bpa_pkg.
module bpa_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  bpa_pkg::div_t din,
    output bpa_pkg::div_t dout
);
    import bpa_pkg::*;

    logic          valid_reg;
    div_t          pay_reg, pay_next;
    logic [MAG_W:0] tu, tv, su, sv, dext;
    logic          geu, gev;

    always_comb
    begin
        dext = {1'b0, din.dmag};
        tu   = {din.ru, din.nu[DVD_W-1]};
        tv   = {din.rv, din.nv[DVD_W-1]};
        su   = tu - dext;
        sv   = tv - dext;
        geu  = tu >= dext;
        gev  = tv >= dext;
        pay_next    = din;
        pay_next.nu = {din.nu[DVD_W-2:0], 1'b0};
        pay_next.nv = {din.nv[DVD_W-2:0], 1'b0};
        pay_next.ru = geu ? su[MAG_W-1:0] : tu[MAG_W-1:0];
        pay_next.rv = gev ? sv[MAG_W-1:0] : tv[MAG_W-1:0];
        pay_next.qu = {din.qu[DVD_W-2:0], geu};
        pay_next.qv = {din.qv[DVD_W-2:0], gev};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pay_reg <= pay_next;
    end

    always_comb
    begin
        dout       = pay_reg;
        dout.valid = valid_reg;
    end

endmodule

@@ sv/bpa_back.sv @@
// Back end: rounding, sign, w = 1 - u - v, saturation and the result register.
// Depends on bpa_pkg and bpa_result_if.
module bpa_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  bpa_pkg::div_t din,
    bpa_result_if.source  result
);
    import bpa_pkg::*;

    logic  r_valid_reg, r_degen_reg, o_valid_reg;
    quot_t qu_reg, qv_reg;
    quot_t qmu, qmv;
    logic  upu, upv;
    wide_t wu, wv, ww;

    function automatic weight_t sat(wide_t a);
        priority if (a > W_HI)
            sat = WEIGHT_BITS'(W_HI);
        else if (a < W_LO)
            sat = WEIGHT_BITS'(W_LO);
        else
            sat = WEIGHT_BITS'(a);
    endfunction

    always_comb
    begin
        // round half away from zero on the magnitude
        upu = {din.ru, 1'b0} >= {1'b0, din.dmag};
        upv = {din.rv, 1'b0} >= {1'b0, din.dmag};
        qmu = quot_t'({1'b0, din.qu}) + quot_t'({{(Q_W-1){1'b0}}, upu});
        qmv = quot_t'({1'b0, din.qv}) + quot_t'({{(Q_W-1){1'b0}}, upv});
        wu  = wide_t'(qu_reg);
        wv  = wide_t'(qv_reg);
        ww  = W_ONE - wu - wv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_valid_reg <= din.valid;
            o_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qu_reg      <= din.neg_u ? -qmu : qmu;
            qv_reg      <= din.neg_v ? -qmv : qmv;
            r_degen_reg <= din.degen;
            result.degenerate <= r_degen_reg;
            result.weight_u   <= r_degen_reg ? '0 : sat(wu);
            result.weight_v   <= r_degen_reg ? '0 : sat(wv);
            result.weight_w   <= r_degen_reg ? '0 : sat(ww);
        end
    end

    assign result.valid = o_valid_reg;

endmodule

@@ sv/barycentric_projected_area.sv @@
// Barycentric weights by projected area. Pipeline of 5 front stages
// (differences, normal products, axis choice, area products, area sums),
// one cell per quotient bit (74 cells), rounding, saturation/output register.
// Throughput one item per cycle; the whole pipe holds while a result waits.
// Reset (rst_n, async, active low) clears all valid bits; no data is reset.
module barycentric_projected_area (
    input  logic         clk,
    input  logic         rst_n,
    bpa_item_if.sink     item,
    bpa_result_if.source result
);
    import bpa_pkg::*;

    logic adv;
    div_t chain [0:DVD_W];

    assign adv = !result.valid || result.ready;

    bpa_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .item  (item),
        .dout  (chain[0])
    );

    for (genvar g = 0; g < DVD_W; g++)
    begin : g_cell
        bpa_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    bpa_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .din    (chain[DVD_W]),
        .result (result)
    );

endmodule

@@ sv/bpa_checker.sv @@
// Port-level checks for barycentric_projected_area, with the bind that attaches them.
// Depends on bpa_pkg.
module bpa_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_ready,
    input logic             res_valid,
    input logic             res_ready,
    input bpa_pkg::weight_t weight_u,
    input bpa_pkg::weight_t weight_v,
    input bpa_pkg::weight_t weight_w,
    input logic             degenerate
);
    import bpa_pkg::*;

    localparam weight_t ONE = weight_t'(2**WEIGHT_FRAC_BITS);

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && degenerate |-> weight_u == '0 && weight_v == '0 && weight_w == '0)
        else $error("degenerate result with nonzero weights");

    a_w_one: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !degenerate && weight_u == '0 && weight_v == '0 |-> weight_w == ONE)
        else $error("w is not one when u and v are zero");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> item_ready)
        else $error("input stalled with empty output");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !item_ready)
        else $error("input taken while output stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(weight_u) && $stable(weight_w))
        else $error("stalled result changed");

endmodule

bind barycentric_projected_area bpa_checker u_bpa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_ready (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .weight_u   (result.weight_u),
    .weight_v   (result.weight_v),
    .weight_w   (result.weight_w),
    .degenerate (result.degenerate)
);

@@ dv/tb.sv @@
// Self-checking bench for barycentric_projected_area: random and directed triangles,
// weights predicted by exact wide integer math. Depends on bpa_pkg and bpa_if.
module tb;
    import bpa_pkg::*;

    typedef struct packed {
        coord_t ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz;
    } tri_item_t;

    typedef struct packed {
        weight_t u, v, w;
        logic    degen;
    } weights_t;

    typedef logic signed [127:0] big_t;

    localparam int LATENCY = 81;
    localparam int LIMIT   = 400000;

    logic clk;
    logic rst_n;

    bpa_item_if   item ();
    bpa_result_if result ();

    barycentric_projected_area DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    tri_item_t pending_q[$];
    weights_t  weights_q[$];
    int        errors;
    int        cycles;
    bit        stim_done;
    bit        calm;         // no idling on either side
    bit        hold_rx;      // receiver hold-off request
    bit        hold_tx;      // sender drains before going on
    int        hold_cnt;

    // doubled signed area of (p1,p2,p3) in the plane of axes i, j
    function automatic big_t area2(big_t p1[3], big_t p2[3], big_t p3[3], int i, int j);
        area2 = (p2[i] - p1[i]) * (p3[j] - p2[j]) - (p3[i] - p2[i]) * (p2[j] - p1[j]);
    endfunction

    function automatic big_t div_round(big_t n, big_t d);
        big_t an, ad, q, r;
        an = n < 0 ? -n : n;
        ad = d < 0 ? -d : d;
        q = an / ad;
        r = an % ad;
        if (2 * r >= ad)
            q = q + 1;
        div_round = ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic weight_t clamp32(big_t a);
        if (a > big_t'(W_HI))
            clamp32 = weight_t'(W_HI);
        else if (a < big_t'(W_LO))
            clamp32 = weight_t'(W_LO);
        else
            clamp32 = weight_t'(a);
    endfunction

    function automatic weights_t bary_weights(tri_item_t t);
        big_t va[3], vb[3], vc[3], vp[3], nrm[3], mg[3], num_u, num_v, qu, qv, one;
        int axis, i, j;
        weights_t res;
        va = '{big_t'(t.ax), big_t'(t.ay), big_t'(t.az)};
        vb = '{big_t'(t.bx), big_t'(t.by), big_t'(t.bz)};
        vc = '{big_t'(t.cx), big_t'(t.cy), big_t'(t.cz)};
        vp = '{big_t'(t.px), big_t'(t.py), big_t'(t.pz)};
        nrm[0] = area2(va, vb, vc, 1, 2);
        nrm[1] = area2(va, vb, vc, 0, 2);
        nrm[2] = area2(va, vb, vc, 0, 1);
        for (int k = 0; k < 3; k++)
            mg[k] = nrm[k] < 0 ? -nrm[k] : nrm[k];
        res = '0;
        if (mg[0] == 0 && mg[1] == 0 && mg[2] == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        if (mg[0] >= mg[1] && mg[0] >= mg[2])
            axis = 0;
        else if (mg[1] >= mg[2])
            axis = 1;
        else
            axis = 2;
        i = axis == 0 ? 1 : 0;
        j = axis == 2 ? 1 : 2;
        num_u = area2(vp, vb, vc, i, j);
        num_v = area2(vp, vc, va, i, j);
        qu = div_round(num_u <<< WEIGHT_FRAC_BITS, nrm[axis]);
        qv = div_round(num_v <<< WEIGHT_FRAC_BITS, nrm[axis]);
        one = big_t'(1) <<< WEIGHT_FRAC_BITS;
        res.u = clamp32(qu);
        res.v = clamp32(qv);
        res.w = clamp32(one - qu - qv);
        return res;
    endfunction

    function automatic coord_t rnd_coord(int mode);
        case (mode)
            0: rnd_coord = coord_t'($urandom);
            1: rnd_coord = coord_t'($urandom_range(0, 2047)) - coord_t'(1024);
            default: rnd_coord = $urandom_range(0, 1) ? coord_t'(24'h7FFFFF)
                                                      : coord_t'(24'h800000);
        endcase
    endfunction

    function automatic tri_item_t rnd_tri();
        tri_item_t t;
        int mode;
        mode = $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 9) < 8 ? 1 : 2);
        t = {rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
             rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
             rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode)};
        case ($urandom_range(0, 15))
            0: t.cx = t.bx;                                          // collinear-ish
            1: begin t.bx = t.ax; t.by = t.ay; t.bz = t.az; end      // zero normal
            2: begin t.az = '0; t.bz = '0; t.cz = '0; end            // z plane
            3: begin t.ay = t.by; t.cy = t.by; end                   // y plane
            default: ;
        endcase
        return t;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item.valid <= 1'b0;
            {item.ax, item.ay, item.az, item.bx, item.by, item.bz,
             item.cx, item.cy, item.cz, item.px, item.py, item.pz} <= '0;
        end
        else if (!item.valid || item.ready)
        begin
            if (pending_q.size() != 0 && !hold_tx && (calm || $urandom_range(0, 99) >= 21))
            begin
                tri_item_t t;
                t = pending_q.pop_front();
                weights_q.push_back(bary_weights(t));
                {item.ax, item.ay, item.az, item.bx, item.by, item.bz,
                 item.cx, item.cy, item.cz, item.px, item.py, item.pz} <= t;
                item.valid <= 1'b1;
            end
            else
                item.valid <= 1'b0;
        end
    end

    // receiver: random stalls plus a long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            hold_cnt <= 0;
        end
        else
        begin
            if (hold_rx && hold_cnt == 0)
                hold_cnt <= 300;
            else if (hold_cnt > 1)
                hold_cnt <= hold_cnt - 1;
            result.ready <= (hold_cnt > 1 || (hold_rx && hold_cnt == 0)) ? 1'b0
                          : (calm || $urandom_range(0, 99) >= 21);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (weights_q.size() == 0)
            begin
                $display("%0t: unexpected transfer u=%h v=%h w=%h degen=%b", $time,
                         result.weight_u, result.weight_v, result.weight_w,
                         result.degenerate);
                errors++;
            end
            else
            begin
                weights_t e;
                e = weights_q.pop_front();
                if (result.weight_u !== e.u)
                begin
                    $display("%0t: weight_u exp %h got %h", $time, e.u, result.weight_u);
                    errors++;
                end
                if (result.weight_v !== e.v)
                begin
                    $display("%0t: weight_v exp %h got %h", $time, e.v, result.weight_v);
                    errors++;
                end
                if (result.weight_w !== e.w)
                begin
                    $display("%0t: weight_w exp %h got %h", $time, e.w, result.weight_w);
                    errors++;
                end
                if (result.degenerate !== e.degen)
                begin
                    $display("%0t: degenerate exp %b got %b", $time, e.degen,
                             result.degenerate);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        tri_item_t t;
        errors = 0;
        cycles = 0;
        stim_done = 0;
        calm = 0;
        hold_rx = 0;
        hold_tx = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: unit triangles on each plane, extremes, zero normal, ties
        t = '0; t.bx = 24'sd256; t.cy = 24'sd256; t.px = 24'sd64; t.py = 24'sd64;
        pending_q.push_back(t);
        t = '0; t.by = 24'sd256; t.cz = 24'sd256; t.py = 24'sd100;
        pending_q.push_back(t);
        t = '0; t.bx = 24'sd256; t.cz = 24'sd256; t.pz = 24'sd100;
        pending_q.push_back(t);
        t = '0;
        pending_q.push_back(t);
        t = {12{24'h7FFFFF}};
        pending_q.push_back(t);
        t = '0; t.bx = 24'sd256; t.by = 24'sd256; t.bz = 24'sd256;
        t.cx = 24'sd512; t.cy = 24'sd512; t.cz = 24'sd512;
        pending_q.push_back(t);
        // equal |n| on all axes
        t = '0; t.bx = 24'sd256; t.by = -24'sd256; t.cy = 24'sd256; t.cz = -24'sd256;
        pending_q.push_back(t);
        t = '0; t.ax = 24'h800000; t.bx = 24'h7FFFFF; t.cy = 24'h7FFFFF;
        t.px = 24'h800000; t.py = 24'h7FFFFF; t.pz = 24'h800000;
        pending_q.push_back(t);
        // tiny triangle, far point: saturates
        t = '0; t.bx = 24'sd1; t.cy = 24'sd1; t.px = 24'h7FFFFF; t.py = 24'h800000;
        pending_q.push_back(t);
        t = '0; t.ax = 24'h800000; t.ay = 24'h800000; t.az = 24'h800000;
        t.bx = 24'h7FFFFF; t.cy = 24'h7FFFFF; t.cz = 24'h7FFFFF;
        t.px = 24'h7FFFFF; t.py = 24'h800000; t.pz = 24'h7FFFFF;
        pending_q.push_back(t);
        for (int k = 0; k < 150; k++)
            pending_q.push_back(rnd_tri());
        wait (pending_q.size() == 0);

        // sender pause until drained
        hold_tx = 1;
        wait (weights_q.size() == 0);
        hold_tx = 0;

        // receiver hold-off while the sender keeps offering
        calm = 1;
        for (int k = 0; k < 300; k++)
            pending_q.push_back(rnd_tri());
        hold_rx = 1;
        // keep the request up until the receiver has latched it
        wait (hold_cnt != 0);
        hold_rx = 0;
        wait (pending_q.size() == 0);
        calm = 0;

        for (int k = 0; k < 550; k++)
            pending_q.push_back(rnd_tri());
        wait (pending_q.size() == 0);
        wait (weights_q.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
